/* rtl/acs_pkg.sv */
package acs_pkg;

  localparam int unsigned STORE_WORDS = 32;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned OP_LSB      = 13;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_STEP    = 3'd0,
    ACT_DEPOSIT = 3'd1,
    ACT_EXAMINE = 3'd2,
    ACT_SET_CTR = 3'd3,
    ACT_SET_ACC = 3'd4
  } act_t;

  localparam logic [2:0] OP_JMP  = 3'd0;
  localparam logic [2:0] OP_JRP  = 3'd1;
  localparam logic [2:0] OP_LDN  = 3'd2;
  localparam logic [2:0] OP_STO  = 3'd3;
  localparam logic [2:0] OP_SUB  = 3'd4;
  localparam logic [2:0] OP_SUB2 = 3'd5;
  localparam logic [2:0] OP_SKN  = 3'd6;
  localparam logic [2:0] OP_STP  = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACT,
    S_FETCH,
    S_OPER
  } state_t;

  typedef struct packed {
    logic  re;
    addr_t raddr;
    logic  we;
    addr_t waddr;
    word_t wdata;
  } mem_req_t;

endpackage

/* rtl/acs_if.sv */
interface acs_in_if;
  logic                                valid;
  logic                                ready;
  logic [acs_pkg::ACT_W-1:0]           action;
  logic [acs_pkg::ADDR_W-1:0]          address;
  logic [acs_pkg::WORD_W-1:0]          data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink   (input valid, input action, input address, input data, output ready);
endinterface

interface acs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic [acs_pkg::WORD_W-1:0]          read_data;
  logic [acs_pkg::ADDR_W-1:0]          counter_out;
  logic signed [acs_pkg::WORD_W-1:0]   accumulator_out;
  logic [acs_pkg::WORD_W-1:0]          instruction_out;

  modport source (output valid, output status, output read_data, output counter_out,
                  output accumulator_out, output instruction_out, input ready);
  modport sink   (input valid, input status, input read_data, input counter_out,
                  input accumulator_out, input instruction_out, output ready);
endinterface

/* rtl/acs_store.sv */
module acs_store (
  input  logic              clk,
  input  logic              rst_n,
  input  acs_pkg::mem_req_t req,
  output acs_pkg::word_t    rdata
);
  import acs_pkg::*;

  word_t                  mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] valid_r;
  word_t                  rdata_r;

  // written entries only; unwritten words read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // write-first on a same-entry collision
  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rdata_r <= req.wdata;
      end else if (valid_r[req.raddr]) begin
        rdata_r <= mem[req.raddr];
      end else begin
        rdata_r <= '0;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/accumulator_cpu_32_word_store.sv */
// channel | dir | beat contents                                         | handshake
// in_ch   | in  | action, address, data                                 | valid/ready
// out_ch  | out | status, read_data, counter_out, accumulator_out,      | valid/ready
//         |     | instruction_out                                       |
// Deposit, examine, set counter and set accumulator end in S_ACT, so they
// stream one per cycle while out_ch is not stalled. A step ends in S_FETCH
// (store, skip, stop) or in S_OPER (jumps, load negated, subtract: operand
// read), as the store has a single read port. Reset clears the state and the
// store's written-entry flags. A full result register with out_ch.ready low
// holds the engine; in_ch.ready stays high while the engine is idle.
module accumulator_cpu_32_word_store (
  input logic  clk,
  input logic  rst_n,
  acs_in_if.sink    in_ch,
  acs_out_if.source out_ch
);
  import acs_pkg::*;

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  addr_t             addr_r;
  word_t             data_r;
  addr_t             ctr_r, ctr_nxt, ctr_upd;
  word_t             acc_r, acc_nxt;
  word_t             pinst_r, pinst_nxt;
  word_t             rdata;
  mem_req_t          req;
  logic              fin, status, out_free, in_fire;
  word_t             rd;
  logic [2:0]        op;

  logic              out_valid_r;
  logic              out_status_r;
  word_t             out_rd_r;
  addr_t             out_ctr_r;
  word_t             out_acc_r;
  word_t             out_inst_r;

  acs_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) || fin;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    fin       = 1'b0;
    status    = 1'b0;
    rd        = '0;
    ctr_upd   = ctr_r;
    acc_nxt   = acc_r;
    pinst_nxt = pinst_r;
    req       = '0;
    state_nxt = state_r;
    op        = rdata[OP_LSB +: 3];

    case (state_r)
      S_ACT: begin
        if (out_free) begin
          fin = 1'b1;
          case (act_r)
            ACT_DEPOSIT: begin
              req.we    = 1'b1;
              req.waddr = addr_r;
              req.wdata = data_r;
            end
            ACT_EXAMINE: rd = rdata;
            ACT_SET_CTR: ctr_upd = data_r[ADDR_W-1:0];
            ACT_SET_ACC: acc_nxt = data_r;
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (op inside {OP_JMP, OP_JRP, OP_LDN, OP_SUB, OP_SUB2}) begin
          pinst_nxt = rdata;
          req.re    = 1'b1;
          req.raddr = rdata[ADDR_W-1:0];
          state_nxt = S_OPER;
        end else if (out_free) begin
          fin       = 1'b1;
          pinst_nxt = rdata;
          case (op)
            OP_STO: begin
              req.we    = 1'b1;
              req.waddr = rdata[ADDR_W-1:0];
              req.wdata = acc_r;
            end
            OP_SKN: begin
              if (acc_r[WORD_W-1]) ctr_upd = ctr_r + addr_t'(1);
            end
            OP_STP: status = 1'b1;
            default: ;
          endcase
        end
      end
      S_OPER: begin
        if (out_free) begin
          fin = 1'b1;
          case (pinst_r[OP_LSB +: 3])
            OP_JMP:          ctr_upd = rdata[ADDR_W-1:0];
            OP_JRP:          ctr_upd = ctr_r + rdata[ADDR_W-1:0];
            OP_LDN:          acc_nxt = word_t'(0) - rdata;
            OP_SUB, OP_SUB2: acc_nxt = acc_r - rdata;
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    if (fin) state_nxt = S_IDLE;

    ctr_nxt = ctr_upd;
    if (in_fire) begin
      req.re = 1'b1;
      if (in_ch.action == ACT_STEP) begin
        ctr_nxt   = ctr_upd + addr_t'(1);
        req.raddr = ctr_nxt;
        state_nxt = S_FETCH;
      end else begin
        req.raddr = in_ch.address;
        state_nxt = S_ACT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r   <= '0;
      acc_r   <= '0;
      pinst_r <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      acc_r   <= acc_nxt;
      pinst_r <= pinst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_ch.action;
      addr_r <= in_ch.address;
      data_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= status;
      out_rd_r     <= rd;
      out_ctr_r    <= ctr_upd;
      out_acc_r    <= acc_nxt;
      out_inst_r   <= pinst_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.read_data       = out_rd_r;
  assign out_ch.counter_out     = out_ctr_r;
  assign out_ch.accumulator_out = out_acc_r;
  assign out_ch.instruction_out = out_inst_r;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import acs_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic  stop;
    word_t read_data;
    addr_t counter;
    word_t acc;
    word_t instr;
  } cpu_result_t;

  logic clk;
  logic rst_n;

  acs_in_if  in_ch();
  acs_out_if out_ch();

  accumulator_cpu_32_word_store uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  word_t mirror_store [STORE_WORDS];
  word_t mirror_acc;
  word_t mirror_instr;
  addr_t mirror_ctr;

  cpu_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int checked_count  = 0;
  int action_count   = 0;
  int step_count     = 0;
  int stop_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t make_instr(logic [2:0] op, addr_t ea);
    word_t w;
    w = '0;
    w[OP_LSB +: 3] = op;
    w[ADDR_W-1:0] = ea;
    return w;
  endfunction

  // Runs one action on the mirrored machine state and returns the beat it should produce.
  function automatic cpu_result_t execute_action(logic [2:0] act, addr_t a, word_t d);
    cpu_result_t r;
    logic [2:0]  op;
    addr_t       ea;
    r.stop = 1'b0;
    r.read_data = '0;
    case (act)
      ACT_STEP: begin
        mirror_ctr = mirror_ctr + addr_t'(1);
        mirror_instr = mirror_store[mirror_ctr];
        op = mirror_instr[OP_LSB +: 3];
        ea = mirror_instr[ADDR_W-1:0];
        case (op)
          OP_JMP: mirror_ctr = mirror_store[ea][ADDR_W-1:0];
          OP_JRP: mirror_ctr = mirror_ctr + mirror_store[ea][ADDR_W-1:0];
          OP_LDN: mirror_acc = -mirror_store[ea];
          OP_STO: mirror_store[ea] = mirror_acc;
          OP_SUB, OP_SUB2: mirror_acc = mirror_acc - mirror_store[ea];
          OP_SKN: if (mirror_acc[WORD_W-1]) mirror_ctr = mirror_ctr + addr_t'(1);
          default: r.stop = 1'b1;
        endcase
      end
      ACT_DEPOSIT: mirror_store[a] = d;
      ACT_EXAMINE: r.read_data = mirror_store[a];
      ACT_SET_CTR: mirror_ctr = d[ADDR_W-1:0];
      ACT_SET_ACC: mirror_acc = d;
      default: ;
    endcase
    r.counter = mirror_ctr;
    r.acc = mirror_acc;
    r.instr = mirror_instr;
    return r;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    error_count++;
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Holds valid across back-to-back beats; drops it only for an idle gap.
  task automatic send_item(logic [2:0] act, addr_t a, word_t d);
    cpu_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.address <= a;
    in_ch.data    <= d;
    do @(posedge clk); while (!in_ch.ready);
    r = execute_action(act, a, d);
    pending_results.push_back(r);
    action_count++;
    if (act == ACT_STEP) step_count++;
    if (r.stop) stop_count++;
  endtask

  always @(posedge clk) begin
    cpu_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending", out_ch.instruction_out, '0);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_ch.status !== want.stop)
          report_mismatch("status", word_t'(out_ch.status), word_t'(want.stop));
        if (out_ch.read_data !== want.read_data)
          report_mismatch("read_data", out_ch.read_data, want.read_data);
        if (out_ch.counter_out !== want.counter)
          report_mismatch("counter_out", word_t'(out_ch.counter_out), word_t'(want.counter));
        if (word_t'(out_ch.accumulator_out) !== want.acc)
          report_mismatch("accumulator_out", word_t'(out_ch.accumulator_out), want.acc);
        if (out_ch.instruction_out !== want.instr)
          report_mismatch("instruction_out", out_ch.instruction_out, want.instr);
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_direct_access();
    send_item(ACT_DEPOSIT, 5'd0, 32'hFFFF_FFFF);
    send_item(ACT_DEPOSIT, 5'd31, 32'h8000_0000);
    send_item(ACT_EXAMINE, 5'd31, 32'h0);
    send_item(ACT_SET_CTR, 5'd0, 32'hFFFF_FFE3);   // upper bits dropped
    send_item(ACT_SET_ACC, 5'd31, 32'h7FFF_FFFF);
    send_item(ACT_UNUSED_LO, 5'd17, 32'hA5A5_A5A5);
    send_item(ACT_UNUSED_HI, 5'd14, 32'h5A5A_5A5A);
  endtask

  // Short program: negated load, taken skip, both subtracts, store, relative jump
  // onto a stop word with noise in the upper bits, then an indirect jump that wraps
  // the counter back to word 0.
  task automatic test_opcode_program();
    send_item(ACT_DEPOSIT, 5'd0, make_instr(OP_LDN, 5'd31));
    send_item(ACT_DEPOSIT, 5'd1, make_instr(OP_SKN, 5'd0));
    send_item(ACT_DEPOSIT, 5'd3, make_instr(OP_SUB, 5'd31));
    send_item(ACT_DEPOSIT, 5'd4, make_instr(OP_SUB2, 5'd4));
    send_item(ACT_DEPOSIT, 5'd5, make_instr(OP_STO, 5'd29));
    send_item(ACT_DEPOSIT, 5'd6, make_instr(OP_JRP, 5'd8));
    send_item(ACT_DEPOSIT, 5'd8, 32'hFFFF_FFE1);
    send_item(ACT_DEPOSIT, 5'd9, make_instr(OP_JMP, 5'd10));
    send_item(ACT_DEPOSIT, 5'd10, 32'hFFFF_FFFF);
    send_item(ACT_SET_CTR, 5'd0, 32'd31);
    repeat (9) send_item(ACT_STEP, '0, '0);
    send_item(ACT_EXAMINE, 5'd29, '0);
  endtask

  // Loads a random program, then mostly steps with edits, reads and register pokes mixed in.
  task automatic test_random_programs(int items, int send_pct, int stall_pct);
    logic [2:0] act;
    addr_t      a;
    word_t      d;
    int         pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < STORE_WORDS; i++) begin
      d = $urandom;
      d[OP_LSB +: 3] = 3'($urandom_range(7));
      send_item(ACT_DEPOSIT, addr_t'(i), d);
    end
    for (int n = STORE_WORDS; n < items; n++) begin
      pick = $urandom_range(99);
      a = addr_t'($urandom_range(STORE_WORDS - 1));
      d = $urandom;
      if (pick < 55) begin
        act = ACT_STEP;
      end else if (pick < 67) begin
        act = ACT_DEPOSIT;
        d[OP_LSB +: 3] = 3'($urandom_range(7));
      end else if (pick < 72) begin
        act = ACT_DEPOSIT;
      end else if (pick < 82) begin
        act = ACT_EXAMINE;
      end else if (pick < 88) begin
        act = ACT_SET_CTR;
      end else if (pick < 95) begin
        act = ACT_SET_ACC;
        if ($urandom_range(3) == 0) d = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        act = 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end
      send_item(act, a, d);
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_STEP;
    in_ch.address <= '0;
    in_ch.data    <= '0;
    foreach (mirror_store[i]) mirror_store[i] = '0;
    mirror_acc   = '0;
    mirror_instr = '0;
    mirror_ctr   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_direct_access();
    test_opcode_program();
    test_random_programs(600, 0, 0);
    test_random_programs(450, 86, 0);
    test_random_programs(450, 0, 86);
    test_random_programs(450, 12, 12);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d actions: %0d steps, %0d of them stops; %0d result beats checked.",
             action_count, step_count, stop_count, checked_count);
    $display("Flow phases: free running, sender gaps, receiver stalls, light gaps on both.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
